// File: rtl/va3_pkg.sv
// shared constants, types and the arctangent table for the vector angle block
package va3_pkg;

	localparam int STEPS = 61;
	localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;
	localparam logic signed [63:0] HALF_PI_Q60 = 64'sh1921FB54442D1846;
	localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;

	// one cordic lane: vector and angle accumulator
	typedef struct packed {
		logic valid;
		logic zero;
		logic done;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
	} lane_t;

	// arctangent of 2^-i in q60, alternating series with truncated terms
	function automatic logic signed [63:0] atan_q60(input int i);
		logic signed [63:0] acc;
		int e;
		acc = 64'sd0;
		if (i == 0) begin
			acc = QUARTER_PI_Q60;
		end else begin
			for (int k = 0; k < 31; k++) begin
				e = 60 - i * (2 * k + 1);
				if (e >= 0) begin
					if (k % 2 == 1)
						acc = acc - 64'(((64'd1 << e) / 64'(2 * k + 1)));
					else
						acc = acc + 64'(((64'd1 << e) / 64'(2 * k + 1)));
				end
			end
		end
		return acc;
	endfunction

endpackage

// File: rtl/va3_cordic_step.sv
// one registered vectoring rotation with a constant shift
module va3_cordic_step #(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  va3_pkg::lane_t d,
	output va3_pkg::lane_t q
);

	localparam logic signed [63:0] ATAN = va3_pkg::atan_q60(SHIFT);

	va3_pkg::lane_t nxt;
	va3_pkg::lane_t lane_q;
	logic valid_q;

	always_comb begin
		nxt = d;
		if (!d.done) begin
			if (d.y >= 0) begin
				nxt.x = d.x + (d.y >>> SHIFT);
				nxt.y = d.y - (d.x >>> SHIFT);
				nxt.z = d.z + ATAN;
			end else begin
				nxt.x = d.x - (d.y >>> SHIFT);
				nxt.y = d.y + (d.x >>> SHIFT);
				nxt.z = d.z - ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

	always_comb begin
		q = lane_q;
		q.valid = valid_q;
	end

endmodule

// File: rtl/vector_angle_3d.sv
// vector_angle_3d: angle between two 3-d vectors, atan2 of cross and dot by cordic
// latency: 103 register stages, set by the 61 cordic rotation stages and the
// one-bit-per-stage square root
// throughput: one transaction per cycle; the whole pipe advances when the output is free
// reset: arst_n clears all valid bits asynchronously, data registers are not reset
module vector_angle_3d #(
	parameter int COMPONENT_BITS = 16,
	parameter int ANGLE_FRACTION_BITS = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, zero pad
	input  logic [((6 * COMPONENT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// angle, zero pad
	output logic [((ANGLE_FRACTION_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
	// zero_vector
	output logic m_tuser
);

	localparam int CB = COMPONENT_BITS;
	localparam int AW = ANGLE_FRACTION_BITS + 2;
	localparam int OW = ((AW + 7) / 8) * 8;
	localparam int SQN = 32;

	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: magnitudes and reduction of each vector
	logic v_s1;
	logic signed [CB-1:0] comp_in [6];
	logic [CB:0] mag [6];
	logic [5:0] neg_s1;
	logic [CB:0] top0, top1;
	logic [CB:0] mag_s1 [6];
	logic [CB:0] top_s1 [2];

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			comp_in[j] = s_tdata[j*CB +: CB];
			mag[j] = comp_in[j][CB-1] ? (CB+1)'(-{comp_in[j][CB-1], comp_in[j]})
				: {1'b0, comp_in[j]};
		end
		top0 = mag[0] | mag[1] | mag[2];
		top1 = mag[3] | mag[4] | mag[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	// true max needed for shift; take max here, keep or-reduce for zero test
	logic [CB:0] mx0, mx1;
	always_comb begin
		mx0 = mag[0];
		if (mag[1] > mx0) mx0 = mag[1];
		if (mag[2] > mx0) mx0 = mag[2];
		mx1 = mag[3];
		if (mag[4] > mx1) mx1 = mag[4];
		if (mag[5] > mx1) mx1 = mag[5];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 6; j++) begin
				mag_s1[j] <= mag[j];
				neg_s1[j] <= comp_in[j][CB-1];
			end
			top_s1[0] <= (top0 == '0) ? '0 : mx0;
			top_s1[1] <= (top1 == '0) ? '0 : mx1;
		end
	end

	// stage 2: shift amount and reduced signed 18-bit components
	// smallest shift that brings the largest magnitude to 2^15 or below
	function automatic logic [5:0] red_shift(input logic [CB:0] t);
		logic [5:0] s;
		s = '0;
		for (int i = 0; i <= CB; i++)
			if ((64'(t) >> i) > 64'd32768) s = 6'(i + 1);
		return s;
	endfunction

	logic v_s2;
	logic zero_s2;
	logic signed [17:0] r_s2 [6];
	logic [5:0] sh0, sh1;
	logic [CB:0] rm [6];
	assign sh0 = red_shift(top_s1[0]);
	assign sh1 = red_shift(top_s1[1]);
	always_comb begin
		for (int j = 0; j < 6; j++)
			rm[j] = mag_s1[j] >> ((j < 3) ? sh0 : sh1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s2 <= (top_s1[0] == '0) || (top_s1[1] == '0);
			for (int j = 0; j < 6; j++)
				r_s2[j] <= neg_s1[j] ? -18'(signed'({1'b0, 17'(rm[j])}))
					: 18'(signed'({1'b0, 17'(rm[j])}));
		end
	end

	// stage 3: products
	logic v_s3, zero_s3;
	logic signed [35:0] p_s3 [9];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s3 <= zero_s2;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					p_s3[i*3+j] <= 36'(r_s2[i]) * 36'(r_s2[3+j]);
		end
	end

	// stage 4: dot and cross
	logic v_s4, zero_s4;
	logic signed [37:0] d_s4;
	logic signed [36:0] c_s4 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s4 <= zero_s3;
			d_s4 <= 38'(p_s3[0]) + 38'(p_s3[4]) + 38'(p_s3[8]);
			c_s4[0] <= 37'(p_s3[5]) - 37'(p_s3[7]);
			c_s4[1] <= 37'(p_s3[6]) - 37'(p_s3[2]);
			c_s4[2] <= 37'(p_s3[1]) - 37'(p_s3[3]);
		end
	end

	// stage 5: squares of cross, magnitudes reach at most 2^31
	logic v_s5, zero_s5;
	logic signed [37:0] d_s5;
	logic [63:0] q_s5 [3];
	logic [31:0] cm [3];
	always_comb
		for (int j = 0; j < 3; j++)
			cm[j] = c_s4[j][36] ? 32'(-c_s4[j]) : 32'(c_s4[j]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s5 <= zero_s4;
			d_s5 <= d_s4;
			for (int j = 0; j < 3; j++)
				q_s5[j] <= 64'(cm[j]) * 64'(cm[j]);
		end
	end

	// stage 6: sum of squares
	logic v_s6, zero_s6;
	logic signed [37:0] d_s6;
	logic [63:0] s_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s6 <= zero_s5;
			d_s6 <= d_s5;
			s_s6 <= 64'(q_s5[0] + q_s5[1] + q_s5[2]);
		end
	end

	// stage 7: normalising scale k
	logic [63:0] ad6;
	logic [4:0] k6;
	assign ad6 = d_s6[37] ? 64'(-d_s6) : 64'(d_s6);
	always_comb begin
		k6 = '0;
		for (int k = 1; k <= 30; k++)
			if ((s_s6 < (64'd1 << (62 - 2 * k))) && (ad6 < (64'd1 << (58 - k))))
				k6 = 5'(k);
	end
	logic v_s7, zero_s7;
	logic signed [63:0] x_s7;
	logic [63:0] n_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s7 <= zero_s6;
			x_s7 <= d_s6[37] ? -signed'(ad6 << k6) : signed'(ad6 << k6);
			n_s7 <= s_s6 << {k6, 1'b0};
		end
	end

	// square root, one result bit per stage
	logic sv [SQN+1];
	logic sz [SQN+1];
	logic signed [63:0] sx [SQN+1];
	logic [63:0] srem [SQN+1];
	logic [31:0] sroot [SQN+1];
	logic [63:0] sn [SQN+1];
	assign sv[0] = v_s7;
	assign sz[0] = zero_s7;
	assign sx[0] = x_s7;
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sn[0] = n_s7;

	for (genvar g = 0; g < SQN; g++) begin : g_sqrt
		logic [65:0] rr, tr;
		always_comb begin
			rr = {srem[g], sn[g][63:62]};
			tr = {32'd0, sroot[g], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[g+1] <= 1'b0;
			else if (adv) sv[g+1] <= sv[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sz[g+1] <= sz[g];
				sx[g+1] <= sx[g];
				sn[g+1] <= {sn[g][61:0], 2'b00};
				if (rr >= tr) begin
					srem[g+1] <= 64'(rr - tr);
					sroot[g+1] <= {sroot[g][30:0], 1'b1};
				end else begin
					srem[g+1] <= 64'(rr);
					sroot[g+1] <= {sroot[g][30:0], 1'b0};
				end
			end
		end
	end

	// pre-rotation and normalisation
	logic signed [63:0] px, py, pz;
	logic pdone;
	logic signed [63:0] yq;
	assign yq = signed'({32'd0, sroot[SQN]});
	always_comb begin
		pdone = 1'b0;
		px = sx[SQN];
		py = yq;
		pz = '0;
		if (yq == 0) begin
			pdone = 1'b1;
			pz = (sx[SQN] > 0) ? 64'sd0 : va3_pkg::PI_Q60;
		end else if (sx[SQN] < 0) begin
			px = yq;
			py = -sx[SQN];
			pz = va3_pkg::HALF_PI_Q60;
		end
	end

	va3_pkg::lane_t pre_s8, nrm_s9, head;
	logic pv_s8, nv_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pv_s8 <= 1'b0;
		else if (adv) pv_s8 <= sv[SQN];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s8 <= '{valid: sv[SQN], zero: sz[SQN], done: pdone | sz[SQN],
				x: px, y: py, z: pz};
		end
	end

	// shift left until max(|x|,y) reaches 2^58
	logic [63:0] ax8, m8;
	logic [5:0] ls8;
	always_comb begin
		ax8 = pre_s8.x[63] ? 64'(-pre_s8.x) : 64'(pre_s8.x);
		m8 = ax8 | 64'(pre_s8.y);
		ls8 = '0;
		for (int i = 1; i < 59; i++)
			if (m8 < (64'd1 << (58 - i + 1)) && m8 >= (64'd1 << (58 - i)))
				ls8 = 6'(i);
		if (m8 >= (64'd1 << 58) || pre_s8.done) ls8 = '0;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nv_s9 <= 1'b0;
		else if (adv) nv_s9 <= pv_s8;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			nrm_s9 <= '{valid: pv_s8, zero: pre_s8.zero, done: pre_s8.done,
				x: pre_s8.x <<< ls8, y: pre_s8.y <<< ls8, z: pre_s8.z};
		end
	end

	always_comb begin
		head = nrm_s9;
		head.valid = nv_s9;
	end

	va3_pkg::lane_t lane [va3_pkg::STEPS+1];
	assign lane[0] = head;
	for (genvar g = 0; g < va3_pkg::STEPS; g++) begin : g_cordic
		va3_cordic_step #(.SHIFT(g)) u_step (
			.clk(clk), .arst_n(arst_n), .en(adv), .d(lane[g]), .q(lane[g+1])
		);
	end

	// clamp and round
	va3_pkg::lane_t fin;
	logic signed [63:0] zc;
	logic [63:0] rnd;
	assign fin = lane[va3_pkg::STEPS];
	always_comb begin
		zc = fin.z;
		if (zc < 0) zc = '0;
		if (zc > va3_pkg::PI_Q60) zc = va3_pkg::PI_Q60;
		rnd = (64'(zc) + (64'd1 << (59 - ANGLE_FRACTION_BITS))) >> (60 - ANGLE_FRACTION_BITS);
	end

	logic [AW-1:0] angle_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= fin.valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			angle_q <= fin.zero ? '0 : rnd[AW-1:0];
			m_tuser <= fin.zero;
		end
	end
	assign m_tdata = OW'(angle_q);

`ifndef SYNTH
	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> angle_q == '0) else $error("zero vector with nonzero angle");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(angle_q)) else $error("output lost");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input stalled with empty output");
`endif

endmodule
